// ===== design/battery_can_payload_builder_defines.svh =====
`ifndef BATTERY_CAN_PAYLOAD_BUILDER_DEFINES_SVH
`define BATTERY_CAN_PAYLOAD_BUILDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bcpb_pkg.sv =====
package bcpb_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // mag * volt < 2^31
  localparam int PROD_W = 31;
  // floor(p / 10000) == (p * RECIP) >> RECIP_SHIFT, exact for p < 2^31
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP = 32'd3518437209;
  localparam int RECIP_SHIFT = 45;
  localparam int FULL_W = PROD_W + RECIP_W;
  // quotient max 214745
  localparam int QUOT_W = 18;

  typedef struct packed {
    logic [15:0] cur;
    logic [15:0] volt;
    logic [3:0]  alive;
  } meas_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/bcpb_power.sv =====
module bcpb_power (
  input  logic                       clk,
  input  logic                       en_mul,
  input  logic                       en_div,
  input  logic [15:0]                cur,
  input  logic [15:0]                volt,
  output logic                       neg,
  output logic [bcpb_pkg::QUOT_W-1:0] quot
);
  import bcpb_pkg::*;

  logic [15:0]       mag;
  logic [31:0]       prod;
  logic [PROD_W-1:0] prod_r;
  logic              neg1_r;
  logic [FULL_W-1:0] full;
  logic [QUOT_W-1:0] quot_r;
  logic              neg2_r;

  // |-32768| = 0x8000 still fits 16 bits unsigned
  assign mag  = cur[15] ? (~cur + 16'd1) : cur;
  assign prod = mag * volt;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= prod[PROD_W-1:0];
      neg1_r <= cur[15];
    end
  end

  assign full = {{RECIP_W{1'b0}}, prod_r} * {{PROD_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (en_div) begin
      quot_r <= full[RECIP_SHIFT +: QUOT_W];
      neg2_r <= neg1_r;
    end
  end

  assign neg  = neg2_r;
  assign quot = quot_r;

endmodule

// ===== design/bcpb_pack.sv =====
module bcpb_pack (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        neg,
  input  logic [bcpb_pkg::QUOT_W-1:0] quot,
  input  bcpb_pkg::meas_t             meas,
  input  logic [7:0]                  crc_part,
  input  logic [7:0]                  status,
  output logic [63:0]                 payload,
  output logic [15:0]                 power,
  output logic [3:0]                  seq,
  output logic [3:0]                  crc
);
  import bcpb_pkg::*;

  logic [15:0] pwr;
  logic [7:0]  crc_full;
  logic [63:0] payload_r;
  logic [15:0] power_r;
  logic [3:0]  seq_r;
  logic [3:0]  crc_r;

  always_comb begin
    if (neg) begin
      pwr = (quot >= QUOT_W'(32768)) ? 16'h8000 : (~quot[15:0] + 16'd1);
    end else begin
      pwr = (quot > QUOT_W'(32767)) ? 16'h7FFF : quot[15:0];
    end
  end

  assign crc_full = crc8_byte(crc8_byte(crc8_byte(crc_part, pwr[7:0]), pwr[15:8]), status);

  always_ff @(posedge clk) begin
    if (load) begin
      payload_r <= {meas.alive, crc_full[3:0], status, pwr, meas.volt, meas.cur};
      power_r   <= pwr;
      seq_r     <= meas.alive;
      crc_r     <= crc_full[3:0];
    end
  end

  assign payload = payload_r;
  assign power   = power_r;
  assign seq     = seq_r;
  assign crc     = crc_r;

endmodule

// ===== design/battery_can_payload_builder.sv =====
// Throughput: one request per cycle while out_ready stays high, set by the
// 4-register pipeline (input, product, reciprocal quotient, result); each
// stage advances when the next frees.
// Reset (rst_n low, synchronous): all valid flags, the alive counter and the
// status register clear; data registers are not reset.
`include "battery_can_payload_builder_defines.svh"

module battery_can_payload_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_current_tenth_amp,
  input  logic [15:0]        in_voltage_tenth_volt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_payload,
  output logic signed [15:0] out_power_tenth_kw,
  output logic [3:0]         out_sequence_nibble,
  output logic [3:0]         out_crc_nibble,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import bcpb_pkg::*;

  logic        v0_r, v1_r, v2_r, out_v_r;
  logic        v0_nxt, v1_nxt, v2_nxt, out_v_nxt;
  logic [3:0]  alive_r, alive_nxt;
  logic [7:0]  status_r;
  meas_t       m0_r, m1_r, m2_r;
  logic [7:0]  crc1_r, crc2_r;
  logic [7:0]  crc_head;
  logic        rdy1, rdy2, rdy3;
  logic        in_fire, ld1, ld2, ld3;
  logic        neg;
  logic [QUOT_W-1:0] quot;
  logic [15:0] power;

  assign rdy3     = !out_v_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;

  assign in_fire = in_valid && in_ready;
  assign ld1     = v0_r && rdy1;
  assign ld2     = v1_r && rdy2;
  assign ld3     = v2_r && rdy3;

  assign alive_nxt = alive_r + 4'd1;
  assign v0_nxt    = in_fire ? 1'b1 : (ld1 ? 1'b0 : v0_r);
  assign v1_nxt    = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_r);
  assign v2_nxt    = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_r);
  assign out_v_nxt = ld3 ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      out_v_r  <= 1'b0;
      alive_r  <= 4'd0;
      status_r <= 8'd0;
    end else begin
      v0_r    <= v0_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      out_v_r <= out_v_nxt;
      if (in_fire) begin
        alive_r <= alive_nxt;
      end
      if (cfg_we) begin
        status_r <= cfg_wdata;
      end
    end
  end

  // crc over current and voltage bytes, finished in the pack stage
  assign crc_head = crc8_byte(crc8_byte(crc8_byte(crc8_byte(CRC_INIT, m0_r.cur[7:0]),
                    m0_r.cur[15:8]), m0_r.volt[7:0]), m0_r.volt[15:8]);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m0_r <= '{cur: in_current_tenth_amp, volt: in_voltage_tenth_volt, alive: alive_nxt};
    end
    if (ld1) begin
      m1_r   <= m0_r;
      crc1_r <= crc_head;
    end
    if (ld2) begin
      m2_r   <= m1_r;
      crc2_r <= crc1_r;
    end
  end

  bcpb_power u_power (
    .clk    (clk),
    .en_mul (ld1),
    .en_div (ld2),
    .cur    (m0_r.cur),
    .volt   (m0_r.volt),
    .neg    (neg),
    .quot   (quot)
  );

  bcpb_pack u_pack (
    .clk      (clk),
    .load     (ld3),
    .neg      (neg),
    .quot     (quot),
    .meas     (m2_r),
    .crc_part (crc2_r),
    .status   (status_r),
    .payload  (out_payload),
    .power    (power),
    .seq      (out_sequence_nibble),
    .crc      (out_crc_nibble)
  );

  assign out_valid          = out_v_r;
  assign out_power_tenth_kw = power;

  `BCPB_ASSERT_NOW(a_byte7_fields, out_valid, out_payload[63:56] == {out_sequence_nibble, out_crc_nibble}, "byte 7 mismatch")
  `BCPB_ASSERT_NOW(a_power_field, out_valid, out_payload[47:32] == out_power_tenth_kw, "power bytes mismatch")
  `BCPB_ASSERT_NOW(a_full_when_blocked, !in_ready, v0_r && v1_r && v2_r && out_v_r && !out_ready, "input blocked with a free stage")
  `BCPB_ASSERT_NEXT(a_alive_step, in_valid && in_ready, m0_r.alive == alive_r, "alive counter not stored")

endmodule

// ===== verif/battery_can_payload_builder_test.sv =====
`timescale 1ns / 1ps

module battery_can_payload_builder_test;

  localparam logic [7:0] FRAME_CRC_POLY = 8'h31;
  localparam logic [7:0] FRAME_CRC_SEED = 8'hFF;
  localparam longint POWER_DIVISOR = 10000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PIPE_LATENCY = 4;

  typedef struct {
    logic [63:0] payload;
    logic [15:0] power;
    logic [3:0]  seq;
    logic [3:0]  crc;
  } can_frame_t;

  class can_frame_scoreboard;
    can_frame_t pending[$];
    logic [7:0] status_reg;
    logic [3:0] alive;
    int mismatches;
    int frames_checked;
    int requests_noted;

    function new();
      status_reg = 8'h00;
      alive = 4'h0;
      mismatches = 0;
      frames_checked = 0;
      requests_noted = 0;
    endfunction

    function void set_status(logic [7:0] v);
      status_reg = v;
    endfunction

    function logic [15:0] power_of(logic [15:0] cur, logic [15:0] volt);
      longint mag;
      longint quot;
      mag = cur[15] ? 64'sd65536 - longint'(cur) : longint'(cur);
      quot = (mag * longint'(volt)) / POWER_DIVISOR;
      if (cur[15]) begin
        if (quot >= 32768) return 16'h8000;
        return 16'(-quot);
      end
      if (quot > 32767) return 16'h7FFF;
      return 16'(quot);
    endfunction

    function logic [7:0] crc8_over(logic [55:0] bytes);
      logic [7:0] c;
      c = FRAME_CRC_SEED;
      for (int i = 0; i < 7; i++) begin
        c = c ^ bytes[8*i +: 8];
        for (int b = 0; b < 8; b++) begin
          c = c[7] ? ({c[6:0], 1'b0} ^ FRAME_CRC_POLY) : {c[6:0], 1'b0};
        end
      end
      return c;
    endfunction

    function void note_request(logic [15:0] cur, logic [15:0] volt);
      can_frame_t f;
      logic [55:0] body;
      logic [7:0] crc_full;
      alive = alive + 4'd1;
      f.power = power_of(cur, volt);
      body = {status_reg, f.power, volt, cur};
      crc_full = crc8_over(body);
      f.crc = crc_full[3:0];
      f.seq = alive;
      f.payload = {f.seq, f.crc, body};
      pending.push_back(f);
      requests_noted++;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      if (mismatches < MAX_REPORTS)
        $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
    endfunction

    function void check_frame(logic [63:0] payload, logic [15:0] power,
                              logic [3:0] seq, logic [3:0] crc);
      can_frame_t want;
      if (pending.size() == 0) begin
        flag("unexpected frame", 64'h0, payload);
        return;
      end
      want = pending.pop_front();
      frames_checked++;
      if (payload !== want.payload) flag("payload", want.payload, payload);
      if (power !== want.power) flag("power", 64'(want.power), 64'(power));
      if (seq !== want.seq) flag("sequence", 64'(want.seq), 64'(seq));
      if (crc !== want.crc) flag("crc", 64'(want.crc), 64'(crc));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_current_tenth_amp = 16'sd0;
  logic [15:0]        in_voltage_tenth_volt = 16'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [63:0]        out_payload;
  logic signed [15:0] out_power_tenth_kw;
  logic [3:0]         out_sequence_nibble;
  logic [3:0]         out_crc_nibble;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = 8'h00;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int status_writes = 0;
  bit drain_timeout = 1'b0;

  can_frame_scoreboard frame_check = new();

  battery_can_payload_builder u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_current_tenth_amp  (in_current_tenth_amp),
    .in_voltage_tenth_volt (in_voltage_tenth_volt),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_payload           (out_payload),
    .out_power_tenth_kw    (out_power_tenth_kw),
    .out_sequence_nibble   (out_sequence_nibble),
    .out_crc_nibble        (out_crc_nibble),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      frame_check.check_frame(out_payload, out_power_tenth_kw,
                              out_sequence_nibble, out_crc_nibble);
  end

  task automatic send_measurement(input logic [15:0] cur, input logic [15:0] volt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_current_tenth_amp <= cur;
    in_voltage_tenth_volt <= volt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_check.note_request(cur, volt);
  endtask

  task automatic drain_frames();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_check.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (frame_check.pending.size() != 0) drain_timeout = 1'b1;
  endtask

  task automatic write_status_byte(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_check.set_status(v);
    status_writes++;
  endtask

  task automatic run_directed();
    send_measurement(16'h0000, 16'd0);
    send_measurement(16'h7FFF, 16'hFFFF);
    send_measurement(16'h8000, 16'hFFFF);
    send_measurement(16'h8000, 16'd0);
    send_measurement(16'h7FFF, 16'd0);
    send_measurement(16'hFFFF, 16'hFFFF);
    // -0.9 and +0.9 truncate to zero
    send_measurement(-16'sd9, 16'd1000);
    send_measurement(16'sd9, 16'd1000);
    // saturation boundaries
    send_measurement(16'h8000, 16'd10000);
    send_measurement(16'h7FFF, 16'd10000);
    send_measurement(16'h7FFF, 16'd10001);
    send_measurement(-16'sd32767, 16'd10000);
    send_measurement(16'sd10000, 16'd10000);
    send_measurement(-16'sd10000, 16'd10000);
    send_measurement(16'h5555, 16'hAAAA);
    send_measurement(16'hAAAA, 16'h5555);
    send_measurement(16'sd1, 16'd1);
    send_measurement(-16'sd1, 16'd1);
    send_measurement(-16'sd1234, 16'd4000);
  endtask

  task automatic run_random(input int count);
    logic [15:0] cur;
    logic [15:0] volt;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          cur = 16'($urandom);
          volt = 16'($urandom);
        end
        3: begin
          cur = 16'(int'($urandom_range(0, 400)) - 200);
          volt = 16'($urandom_range(0, 2500));
        end
        4: begin
          cur = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 2000)) - 32768)
                                     : 16'($urandom_range(30767, 32767));
          volt = 16'($urandom_range(9990, 10012));
        end
        default: begin
          cur = 16'($urandom);
          volt = 16'($urandom_range(60000, 65535));
        end
      endcase
      send_measurement(cur, volt);
    end
  endtask

  initial begin
    int failures;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 71;
    run_directed();
    drain_frames();
    write_status_byte(8'hFF);
    run_random(120);
    drain_frames();
    write_status_byte(8'(($urandom)));
    run_random(110);

    drain_frames();
    send_idle_pct = 71;
    recv_idle_pct = 11;
    write_status_byte(8'h00);
    run_random(120);
    drain_frames();
    write_status_byte(8'(($urandom)));
    run_random(110);

    drain_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_status_byte(8'h80);
    run_random(120);
    drain_frames();
    write_status_byte(8'h7F);
    run_random(120);

    drain_frames();
    repeat (PIPE_LATENCY * 2) @(posedge clk);

    failures = frame_check.mismatches + frame_check.pending.size() + int'(drain_timeout);
    $display("Sent %0d measurement requests under three pacing modes, %0d status settings.",
             frame_check.requests_noted, status_writes);
    $display("Checked %0d frames: %0d mismatches, %0d frames missing.",
             frame_check.frames_checked, frame_check.mismatches,
             frame_check.pending.size());
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timeout waiting on the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule
